>>> src/sparse_polynomial_add_sub_merge_macros.svh
// Assertion macros for the sparse polynomial add/subtract merge unit
`ifndef SPARSE_POLYNOMIAL_ADD_SUB_MERGE_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADD_SUB_MERGE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SPAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spas assertion failed");
// next-cycle implication
`define SPAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spas assertion failed");
`else
`define SPAS_ASSERT_NOW(label, ante, cons)
`define SPAS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/spas_pkg.sv
// Shared types and constants of the sparse polynomial merge unit
package spas_pkg;

  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 16;
  localparam int RES_W     = COEF_W + 1;
  localparam int TERM_W    = COEF_W + EXP_W;

  typedef enum logic [1:0] {
    CMD_LOAD_A    = 2'd0,
    CMD_LOAD_B    = 2'd1,
    CMD_MERGE_ADD = 2'd2,
    CMD_MERGE_SUB = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic merge_start;
    logic merge_step;
    logic empty_emit;
    logic sub;
  } ctl_t;

  typedef struct packed {
    logic tables_empty;
    logic last_step;
  } sts_t;

endpackage

>>> src/spas_ram.sv
// Generic single-write, single-read RAM with registered read data
module spas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/spas_ctrl.sv
// Controller state machine of the sparse polynomial merge unit
module spas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  input  spas_pkg::sts_t    sts,
  output spas_pkg::ctl_t    ctl,
  output logic              busy
);

  spas_pkg::state_t state_r, state_nxt;
  spas_pkg::cmd_t   cmd;
  logic             take;
  logic             is_merge;

  assign cmd      = spas_pkg::cmd_t'(in_command);
  assign take     = start && (state_r == spas_pkg::ST_IDLE);
  assign is_merge = (cmd == spas_pkg::CMD_MERGE_ADD) || (cmd == spas_pkg::CMD_MERGE_SUB);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spas_pkg::ST_IDLE: begin
        if (take && is_merge && !sts.tables_empty) begin
          state_nxt = spas_pkg::ST_MERGE;
        end
      end
      spas_pkg::ST_MERGE: begin
        if (sts.last_step) begin
          state_nxt = spas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b0;
    ctl.sub = (cmd == spas_pkg::CMD_MERGE_SUB);
    unique case (state_r)
      spas_pkg::ST_IDLE: begin
        ctl.load_a      = take && (cmd == spas_pkg::CMD_LOAD_A);
        ctl.load_b      = take && (cmd == spas_pkg::CMD_LOAD_B);
        ctl.merge_start = take && is_merge && !sts.tables_empty;
        ctl.empty_emit  = take && is_merge && sts.tables_empty;
      end
      spas_pkg::ST_MERGE: begin
        ctl.merge_step = 1'b1;
        busy           = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/spas_dp.sv
// Datapath: term tables, counts, merge pointers and result register
module spas_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  spas_pkg::ctl_t                     ctl,
  input  logic                               in_start_new,
  input  logic signed [spas_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spas_pkg::EXP_W-1:0]         in_exponent,
  output spas_pkg::sts_t                     sts,
  output logic                               out_valid,
  output logic signed [spas_pkg::RES_W-1:0]  out_result_coefficient,
  output logic [spas_pkg::EXP_W-1:0]         out_result_exponent,
  output logic                               out_empty_marker,
  output logic                               out_last_term
);

  localparam int CW = spas_pkg::COEF_W;
  localparam int EW = spas_pkg::EXP_W;
  localparam int RW = spas_pkg::RES_W;

  logic [spas_pkg::CNT_W-1:0]  count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  logic [spas_pkg::CNT_W-1:0]  ia_r, ia_nxt, ib_r, ib_nxt;
  logic                        sub_r, sub_nxt;
  logic                        we_a, we_b;
  logic [spas_pkg::IDX_W-1:0]  waddr_a, waddr_b;
  logic [spas_pkg::TERM_W-1:0] wdata, term_a, term_b;
  logic [EW-1:0]               ea, eb;
  logic signed [CW-1:0]        ca, cb;
  logic                        a_has, b_has, take_a, take_b;
  logic signed [RW-1:0]        a_part, b_val, b_part, sum;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [RW-1:0]        out_coef_r, out_coef_nxt;
  logic [EW-1:0]               out_exp_r, out_exp_nxt;
  logic                        out_empty_r, out_empty_nxt;
  logic                        out_last_r, out_last_nxt;

  // Table writes: start_new rewinds to entry zero, a full table drops the term
  assign wdata   = {in_exponent, in_coefficient};
  assign waddr_a = in_start_new ? '0 : count_a_r[spas_pkg::IDX_W-1:0];
  assign waddr_b = in_start_new ? '0 : count_b_r[spas_pkg::IDX_W-1:0];
  assign we_a    = ctl.load_a &&
                   (in_start_new || count_a_r < spas_pkg::CNT_W'(spas_pkg::MAX_TERMS));
  assign we_b    = ctl.load_b &&
                   (in_start_new || count_b_r < spas_pkg::CNT_W'(spas_pkg::MAX_TERMS));

  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    if (we_a) begin
      count_a_nxt = in_start_new ? spas_pkg::CNT_W'(1) : count_a_r + spas_pkg::CNT_W'(1);
    end
    if (we_b) begin
      count_b_nxt = in_start_new ? spas_pkg::CNT_W'(1) : count_b_r + spas_pkg::CNT_W'(1);
    end
  end

  spas_ram #(.WIDTH(spas_pkg::TERM_W), .DEPTH(spas_pkg::MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata),
    .raddr (ia_nxt[spas_pkg::IDX_W-1:0]),
    .rdata (term_a)
  );

  spas_ram #(.WIDTH(spas_pkg::TERM_W), .DEPTH(spas_pkg::MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata),
    .raddr (ib_nxt[spas_pkg::IDX_W-1:0]),
    .rdata (term_b)
  );

  // Heads of both tables, read at the current pointers
  assign ea = term_a[spas_pkg::TERM_W-1:CW];
  assign ca = term_a[CW-1:0];
  assign eb = term_b[spas_pkg::TERM_W-1:CW];
  assign cb = term_b[CW-1:0];

  assign a_has  = ia_r < count_a_r;
  assign b_has  = ib_r < count_b_r;
  assign take_a = a_has && (!b_has || ea <= eb);
  assign take_b = b_has && (!a_has || eb <= ea);

  assign a_part = take_a ? {ca[CW-1], ca} : '0;
  assign b_val  = sub_r ? -{cb[CW-1], cb} : {cb[CW-1], cb};
  assign b_part = take_b ? b_val : '0;
  assign sum    = a_part + b_part;

  always_comb begin
    ia_nxt  = ia_r;
    ib_nxt  = ib_r;
    sub_nxt = sub_r;
    if (ctl.merge_start) begin
      ia_nxt  = '0;
      ib_nxt  = '0;
      sub_nxt = ctl.sub;
    end else if (ctl.merge_step) begin
      ia_nxt = ia_r + spas_pkg::CNT_W'(take_a);
      ib_nxt = ib_r + spas_pkg::CNT_W'(take_b);
    end
  end

  assign sts.tables_empty = (count_a_r == '0) && (count_b_r == '0);
  assign sts.last_step    = ctl.merge_step && (ia_nxt >= count_a_r) && (ib_nxt >= count_b_r);

  always_comb begin
    out_valid_nxt = ctl.merge_step || ctl.empty_emit;
    out_coef_nxt  = out_coef_r;
    out_exp_nxt   = out_exp_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    if (ctl.empty_emit) begin
      out_coef_nxt  = '0;
      out_exp_nxt   = '0;
      out_empty_nxt = 1'b1;
      out_last_nxt  = 1'b1;
    end else if (ctl.merge_step) begin
      out_coef_nxt  = sum;
      out_exp_nxt   = take_a ? ea : eb;
      out_empty_nxt = 1'b0;
      out_last_nxt  = sts.last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r       <= sub_nxt;
    out_coef_r  <= out_coef_nxt;
    out_exp_r   <= out_exp_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_result_coefficient = out_coef_r;
  assign out_result_exponent    = out_exp_r;
  assign out_empty_marker       = out_empty_r;
  assign out_last_term          = out_last_r;

endmodule

>>> src/sparse_polynomial_add_sub_merge.sv
// Top level of the sparse polynomial add/subtract merge unit
//
// Channel   Handshake          Payload
// -------   ----------------   ---------------------------------------------------
// input     start / busy       in_command, in_start_new, in_coefficient, in_exponent
// result    out_valid strobe   out_result_coefficient, out_result_exponent,
//                              out_empty_marker, out_last_term
//
// A transaction on the input is taken at a clock edge with start high and busy low.
// A load never raises busy, so loads may follow back to back. A merge holds busy
// while it steps through its result terms (na + nb at most); the terms come out
// one per cycle, each in the cycle after its step, the last carrying out_last_term.
// A merge over two empty tables gives its single empty marker without raising busy.
// Reset clears both term counts; no clearing pass. The receiver cannot stall results.
`include "sparse_polynomial_add_sub_merge_macros.svh"

module sparse_polynomial_add_sub_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_command,
  input  logic                               in_start_new,
  input  logic signed [spas_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spas_pkg::EXP_W-1:0]         in_exponent,
  output logic                               out_valid,
  output logic signed [spas_pkg::RES_W-1:0]  out_result_coefficient,
  output logic [spas_pkg::EXP_W-1:0]         out_result_exponent,
  output logic                               out_empty_marker,
  output logic                               out_last_term
);

  spas_pkg::ctl_t ctl;
  spas_pkg::sts_t sts;

  // Controller: decode the transaction, sequence the merge walk
  spas_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  // Datapath: hold the tables, advance both pointers, register each result
  spas_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl                    (ctl),
    .in_start_new           (in_start_new),
    .in_coefficient         (in_coefficient),
    .in_exponent            (in_exponent),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_result_coefficient (out_result_coefficient),
    .out_result_exponent    (out_result_exponent),
    .out_empty_marker       (out_empty_marker),
    .out_last_term          (out_last_term)
  );

  // A merge walk only starts from a merge transaction
  `SPAS_ASSERT_NOW(a_busy_from_merge, $rose(busy), $past(start) && ($past(in_command) == spas_pkg::CMD_MERGE_ADD || $past(in_command) == spas_pkg::CMD_MERGE_SUB))
  // Results of one merge come out in consecutive cycles
  `SPAS_ASSERT_NEXT(a_no_gap, out_valid && !out_last_term, out_valid)
  // The end of a walk delivers the final term
  `SPAS_ASSERT_NOW(a_end_last, $fell(busy), out_valid && out_last_term)
  // An empty marker is always the only and last result
  `SPAS_ASSERT_NOW(a_empty_last, out_valid && out_empty_marker, out_last_term && !$past(busy))

endmodule

>>> verif/tb_sparse_polynomial_add_sub_merge.sv
// Self-checking testbench for the sparse polynomial add/subtract merge unit
`timescale 1ns / 1ps

module tb_sparse_polynomial_add_sub_merge;

  // Number of directed rows and of random input transactions to issue
  localparam int N_DIRECTED   = 23;
  localparam int RANDOM_ITEMS = 300;

  // One row of directed stimulus; typed rows carry their single expected term
  typedef struct packed {
    spas_pkg::cmd_t                  cmd;
    logic                            start_new;
    logic [spas_pkg::COEF_W-1:0]     coef;
    logic [spas_pkg::EXP_W-1:0]      expo;
    logic                            typed;
    logic [spas_pkg::RES_W-1:0]      res_coef;
    logic [spas_pkg::EXP_W-1:0]      res_exp;
    logic                            res_empty;
    logic                            res_last;
  } stim_row_t;

  // One emitted term of a merge run
  typedef struct packed {
    logic [spas_pkg::RES_W-1:0] coef;
    logic [spas_pkg::EXP_W-1:0] expo;
    logic                       empty;
    logic                       is_last;
  } poly_term_t;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic [1:0]                         in_command;
  logic                               in_start_new;
  logic signed [spas_pkg::COEF_W-1:0] in_coefficient;
  logic [spas_pkg::EXP_W-1:0]         in_exponent;
  logic                               out_valid;
  logic signed [spas_pkg::RES_W-1:0]  out_result_coefficient;
  logic [spas_pkg::EXP_W-1:0]         out_result_exponent;
  logic                               out_empty_marker;
  logic                               out_last_term;

  // Predictor state: term tables of A (index 0) and B (index 1)
  logic [spas_pkg::COEF_W-1:0] poly_coef [2][spas_pkg::MAX_TERMS];
  logic [spas_pkg::EXP_W-1:0]  poly_exp  [2][spas_pkg::MAX_TERMS];
  int                          poly_len  [2];

  poly_term_t expected_terms[$];
  int         mismatch_count;
  int         items_sent;
  int         idle_pct;

  // Directed part: empty tables, start flag on a merge, coefficient and exponent
  // extremes, zero sum, lone B terms negated on subtract, a tie, an unordered
  // table and the tail of A copied once B runs out
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{spas_pkg::CMD_MERGE_ADD, 1'b0, 16'h0000, 16'h0000, 1'b1, 17'h00000, 16'h0000, 1'b1, 1'b1},
    '{spas_pkg::CMD_MERGE_SUB, 1'b0, 16'h0000, 16'h0000, 1'b1, 17'h00000, 16'h0000, 1'b1, 1'b1},
    '{spas_pkg::CMD_MERGE_ADD, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 17'h00000, 16'h0000, 1'b1, 1'b1},
    '{spas_pkg::CMD_LOAD_A,    1'b1, 16'h7FFF, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_B,    1'b1, 16'h8000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_ADD, 1'b0, 16'h0000, 16'h0000, 1'b1, 17'h1FFFF, 16'h0000, 1'b0, 1'b1},
    '{spas_pkg::CMD_MERGE_SUB, 1'b0, 16'h0000, 16'h0000, 1'b1, 17'h0FFFF, 16'h0000, 1'b0, 1'b1},
    '{spas_pkg::CMD_LOAD_A,    1'b1, 16'h8000, 16'hFFFF, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_B,    1'b1, 16'h8000, 16'hFFFF, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_ADD, 1'b0, 16'h0000, 16'h0000, 1'b1, 17'h10000, 16'hFFFF, 1'b0, 1'b1},
    '{spas_pkg::CMD_MERGE_SUB, 1'b0, 16'h0000, 16'h0000, 1'b1, 17'h00000, 16'hFFFF, 1'b0, 1'b1},
    '{spas_pkg::CMD_LOAD_B,    1'b1, 16'h0005, 16'h0003, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_B,    1'b0, 16'hFFF9, 16'h0009, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_SUB, 1'b0, 16'h0000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_ADD, 1'b0, 16'h0000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_A,    1'b0, 16'h0001, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_ADD, 1'b1, 16'h0000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_SUB, 1'b0, 16'h0000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_A,    1'b1, 16'h1234, 16'h0004, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_A,    1'b0, 16'h00FF, 16'h0009, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_LOAD_A,    1'b0, 16'h7FFF, 16'h8000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_SUB, 1'b0, 16'h0000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0},
    '{spas_pkg::CMD_MERGE_ADD, 1'b0, 16'h0000, 16'h0000, 1'b0, 17'h00000, 16'h0000, 1'b0, 1'b0}
  };

  sparse_polynomial_add_sub_merge i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_command             (in_command),
    .in_start_new           (in_start_new),
    .in_coefficient         (in_coefficient),
    .in_exponent            (in_exponent),
    .out_valid              (out_valid),
    .out_result_coefficient (out_result_coefficient),
    .out_result_exponent    (out_result_exponent),
    .out_empty_marker       (out_empty_marker),
    .out_last_term          (out_last_term)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Count a mismatch and print one line for it
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Update the term tables on a load, or queue every term a merge emits
  task automatic predict_transaction(input spas_pkg::cmd_t cmd, input logic start_new,
                                     input logic [spas_pkg::COEF_W-1:0] coef,
                                     input logic [spas_pkg::EXP_W-1:0] expo);
    int                                t;
    int                                ia;
    int                                ib;
    int                                na;
    int                                nb;
    bit                                take_a;
    bit                                take_b;
    logic signed [spas_pkg::RES_W-1:0] ca;
    logic signed [spas_pkg::RES_W-1:0] cb;
    poly_term_t                        term;
    if (cmd == spas_pkg::CMD_LOAD_A || cmd == spas_pkg::CMD_LOAD_B) begin
      t = (cmd == spas_pkg::CMD_LOAD_B) ? 1 : 0;
      if (start_new) begin
        poly_len[t] = 0;
      end
      // a full table drops the term
      if (poly_len[t] < spas_pkg::MAX_TERMS) begin
        poly_coef[t][poly_len[t]] = coef;
        poly_exp[t][poly_len[t]]  = expo;
        poly_len[t]++;
      end
    end else begin
      na = poly_len[0];
      nb = poly_len[1];
      ia = 0;
      ib = 0;
      if (na == 0 && nb == 0) begin
        term = '{spas_pkg::RES_W'(0), spas_pkg::EXP_W'(0), 1'b1, 1'b1};
        expected_terms.push_back(term);
      end
      // two-pointer walk: smaller head first, both heads on a tie
      while (ia < na || ib < nb) begin
        take_a = (ib >= nb) || (ia < na && poly_exp[0][ia] < poly_exp[1][ib]);
        take_b = !take_a && ((ia >= na) || poly_exp[1][ib] < poly_exp[0][ia]);
        ca = '0;
        cb = '0;
        if (ia < na) begin
          ca = spas_pkg::RES_W'($signed(poly_coef[0][ia]));
        end
        if (ib < nb) begin
          cb = spas_pkg::RES_W'($signed(poly_coef[1][ib]));
        end
        if (cmd == spas_pkg::CMD_MERGE_SUB) begin
          cb = -cb;
        end
        if (take_a) begin
          term.coef = ca;
          term.expo = poly_exp[0][ia];
          ia++;
        end else if (take_b) begin
          term.coef = cb;
          term.expo = poly_exp[1][ib];
          ib++;
        end else begin
          term.coef = ca + cb;
          term.expo = poly_exp[0][ia];
          ia++;
          ib++;
        end
        term.empty   = 1'b0;
        term.is_last = (ia >= na && ib >= nb);
        expected_terms.push_back(term);
      end
    end
  endtask

  // Present one transaction at the falling edge and hold it until busy is low
  // at a rising edge; return in the time step of acceptance
  task automatic issue_transaction(input spas_pkg::cmd_t cmd, input logic start_new,
                                   input logic [spas_pkg::COEF_W-1:0] coef,
                                   input logic [spas_pkg::EXP_W-1:0] expo);
    @(negedge clk);
    start          = 1'b1;
    in_command     = cmd;
    in_start_new   = start_new;
    in_coefficient = coef;
    in_exponent    = expo;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Idle the sender at random per the current phase, then issue and predict
  task automatic send_item(input spas_pkg::cmd_t cmd, input logic start_new,
                           input logic [spas_pkg::COEF_W-1:0] coef,
                           input logic [spas_pkg::EXP_W-1:0] expo);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start          = 1'b0;
      in_command     = 2'($urandom);
      in_start_new   = 1'($urandom);
      in_coefficient = spas_pkg::COEF_W'($urandom);
      in_exponent    = spas_pkg::EXP_W'($urandom);
    end
    issue_transaction(cmd, start_new, coef, expo);
    predict_transaction(cmd, start_new, coef, expo);
    items_sent++;
  endtask

  // Hold the sender off until every queued term has come out
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_terms.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Result checker: every strobe must match the oldest queued term
  always @(posedge clk) begin
    poly_term_t want;
    if (rst_n && out_valid) begin
      if (expected_terms.size() == 0) begin
        report_mismatch($sformatf("unexpected term coef %0d exp %0d empty %0b last %0b",
                                  out_result_coefficient, out_result_exponent,
                                  out_empty_marker, out_last_term));
      end else begin
        want = expected_terms.pop_front();
        if (out_result_coefficient !== want.coef || out_result_exponent !== want.expo ||
            out_empty_marker !== want.empty || out_last_term !== want.is_last) begin
          report_mismatch($sformatf(
            "got coef %0d exp %0d empty %0b last %0b, want %0d %0d %0b %0b",
            out_result_coefficient, out_result_exponent, out_empty_marker,
            out_last_term, $signed(want.coef), want.expo, want.empty, want.is_last));
        end
      end
    end
  end

  initial begin
    int                          seq_no;
    int                          phase;
    int                          cur_phase;
    int                          la;
    int                          lb;
    int                          n;
    logic [spas_pkg::EXP_W-1:0]  base;
    logic [spas_pkg::EXP_W-1:0]  e;
    logic [spas_pkg::COEF_W-1:0] c;
    poly_term_t                  typed_term;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = '0;
    in_start_new   = 1'b0;
    in_coefficient = '0;
    in_exponent    = '0;
    poly_len[0]    = 0;
    poly_len[1]    = 0;
    mismatch_count = 0;
    items_sent     = 0;
    idle_pct       = 0;

    // Hold reset, then release it away from the sampling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows, back to back; typed rows queue their own term
    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_transaction(directed_rows[i].cmd, directed_rows[i].start_new,
                        directed_rows[i].coef, directed_rows[i].expo);
      if (directed_rows[i].typed) begin
        typed_term = '{directed_rows[i].res_coef, directed_rows[i].res_exp,
                       directed_rows[i].res_empty, directed_rows[i].res_last};
        expected_terms.push_back(typed_term);
      end else begin
        predict_transaction(directed_rows[i].cmd, directed_rows[i].start_new,
                            directed_rows[i].coef, directed_rows[i].expo);
      end
    end
    drain_results();

    // Random part: mostly well-formed load sequences followed by merges, with
    // noise transactions and broken sequences mixed in
    seq_no    = 0;
    cur_phase = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // Advance the idling phase every few sequences; drain at each change
      phase = (seq_no / 6) % 3;
      if (phase != cur_phase) begin
        drain_results();
        cur_phase = phase;
      end
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 59;
        default: idle_pct = 10;
      endcase

      // Noise: any command with any fields
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 2)) begin
          send_item(spas_pkg::cmd_t'($urandom_range(0, 3)), 1'($urandom),
                    spas_pkg::COEF_W'($urandom), spas_pkg::EXP_W'($urandom));
        end
      end

      // Table sizes: mostly small, now and then full or overfull
      la = ($urandom_range(0, 99) < 8) ? $urandom_range(28, 34) : $urandom_range(0, 6);
      lb = ($urandom_range(0, 99) < 8) ? $urandom_range(28, 34) : $urandom_range(0, 6);
      if (seq_no == 0) begin
        la = 34;
        lb = 34;
      end
      // Share a base so that A and B exponents often coincide
      base = ($urandom_range(0, 3) == 0) ? spas_pkg::EXP_W'($urandom_range(0, 65535 - 110))
                                         : spas_pkg::EXP_W'($urandom_range(0, 8));

      for (int t = 0; t < 2; t++) begin
        n = (t == 0) ? la : lb;
        e = base + spas_pkg::EXP_W'($urandom_range(0, 2));
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 11))
            0:       c = 16'h7FFF;
            1:       c = 16'h8000;
            2:       c = 16'h0000;
            3:       c = 16'hFFFF;
            default: c = spas_pkg::COEF_W'($urandom);
          endcase
          // first load normally clears; a stray clear or a missing one breaks the run
          send_item((t == 0) ? spas_pkg::CMD_LOAD_A : spas_pkg::CMD_LOAD_B,
                    (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0),
                    c, e);
          e = e + spas_pkg::EXP_W'($urandom_range(1, 3));
        end
      end

      repeat ($urandom_range(1, 2)) begin
        send_item(($urandom_range(0, 1) != 0) ? spas_pkg::CMD_MERGE_SUB
                                              : spas_pkg::CMD_MERGE_ADD,
                  1'($urandom), spas_pkg::COEF_W'($urandom), spas_pkg::EXP_W'($urandom));
      end
      seq_no++;
    end

    // Wait for the last terms, then keep watching for stray strobes
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
